### sv/ehsm_pkg.sv
// Shared constants and types for the encoder hard stop monitor.
package ehsm_pkg;

    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned PADDR_W  = 3;

    typedef logic signed [1:0]         dir_t;
    typedef logic signed [COUNT_W-1:0] count_t;
    typedef logic [TIME_W-1:0]         stamp_t;
    typedef logic [CFG_W-1:0]          cfg_t;

    localparam dir_t DIR_STOP    = 2'sb00;
    localparam dir_t DIR_FORWARD = 2'sb01;
    localparam dir_t DIR_REVERSE = 2'sb11;

    typedef enum logic {
        REG_THRESHOLD   = 1'b0,
        REG_PERSISTENCE = 1'b1
    } reg_index_t;

    localparam cfg_t THRESHOLD_RESET   = 16'd256;
    localparam cfg_t PERSISTENCE_RESET = 16'd100;

endpackage

### sv/encoder_hard_stop_monitor.sv
// Hard stop monitor: tracking error per motion sample with persistence-timed fault.
//
// Use: each input beat on in_valid/in_ready carries one motion sample
// (direction, commanded and measured counts, millisecond timestamp). Each
// accepted beat yields exactly one result beat on out_valid/out_ready with
// hard_stop_fault and tracking_error, in order.
// Direction zero clears the move; a new or changed direction latches the
// origins and reports zero error; later samples report the directional
// tracking error and raise the fault once it has stayed at or above the
// threshold for the persistence time.
// Path: input beat to result beat through the input register, then the result
// register. Throughput: one beat per cycle while out_ready stays high, with the
// state update between the two registers.
// Stall: when out_ready is low the result register holds, the input register
// still fills, and in_ready drops only once both are full.
// Reset (rst_n low, asynchronous): move state cleared, pipeline empty, threshold 256
// counts and persistence 100 ms. Registers are written over the APB port at byte 0
// (threshold) and byte 4 (persistence); the user must do so only while idle (unchecked).
module encoder_hard_stop_monitor (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ehsm_pkg::dir_t               move_direction,
    input  ehsm_pkg::count_t             commanded_counts,
    input  ehsm_pkg::count_t             measured_counts,
    input  ehsm_pkg::stamp_t             sample_time_ms,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hard_stop_fault,
    output ehsm_pkg::count_t             tracking_error,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ehsm_pkg::PADDR_W-1:0] paddr,
    input  logic [ehsm_pkg::PDATA_W-1:0] pwdata,
    output logic [ehsm_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import ehsm_pkg::*;

    cfg_t       threshold_reg;
    cfg_t       persistence_reg;
    reg_index_t cfg_sel;
    logic       cfg_write;

    logic       s1_valid_reg;
    dir_t       s1_dir_reg;
    count_t     s1_delta_reg;
    stamp_t     s1_time_reg;
    dir_t       in_dir;

    logic       armed_reg;
    dir_t       held_dir_reg;
    count_t     origin_delta_reg;
    logic       violation_on_reg;
    stamp_t     violation_start_reg;

    logic       out_valid_reg;
    logic       fault_reg;
    count_t     error_reg;

    logic       out_free;
    logic       s1_move;
    logic       rearm;
    count_t     diff;
    logic       below;
    stamp_t     elapsed;
    logic       expired;

    assign pready    = 1'b1;
    assign cfg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_sel)
            REG_THRESHOLD:   prdata = {{(PDATA_W-CFG_W){1'b0}}, threshold_reg};
            REG_PERSISTENCE: prdata = {{(PDATA_W-CFG_W){1'b0}}, persistence_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RESET;
            persistence_reg <= PERSISTENCE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_THRESHOLD:   threshold_reg   <= pwdata[CFG_W-1:0];
                REG_PERSISTENCE: persistence_reg <= pwdata[CFG_W-1:0];
                default:         threshold_reg   <= threshold_reg;
            endcase
        end
    end

    // fold the out-of-range code onto reverse
    assign in_dir = move_direction[1] ? DIR_REVERSE : move_direction;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_dir_reg   <= in_dir;
            s1_delta_reg <= commanded_counts - measured_counts;
            s1_time_reg  <= sample_time_ms;
        end
    end

    assign rearm   = !armed_reg || (held_dir_reg != s1_dir_reg);
    assign diff    = (s1_dir_reg == DIR_REVERSE) ? (origin_delta_reg - s1_delta_reg)
                                                 : (s1_delta_reg - origin_delta_reg);
    assign below   = diff[COUNT_W-1] ||
                     (diff < $signed({{(COUNT_W-CFG_W){1'b0}}, threshold_reg}));
    assign elapsed = s1_time_reg - violation_start_reg;
    assign expired = elapsed >= {{(TIME_W-CFG_W){1'b0}}, persistence_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg           <= 1'b0;
            held_dir_reg        <= DIR_STOP;
            origin_delta_reg    <= '0;
            violation_on_reg    <= 1'b0;
            violation_start_reg <= '0;
            fault_reg           <= 1'b0;
            error_reg           <= '0;
        end
        else if (s1_move)
        begin
            fault_reg <= 1'b0;
            if (s1_dir_reg == DIR_STOP)
            begin
                armed_reg           <= 1'b0;
                held_dir_reg        <= DIR_STOP;
                origin_delta_reg    <= '0;
                violation_on_reg    <= 1'b0;
                violation_start_reg <= '0;
                error_reg           <= '0;
            end
            else if (rearm)
            begin
                armed_reg        <= 1'b1;
                held_dir_reg     <= s1_dir_reg;
                origin_delta_reg <= s1_delta_reg;
                violation_on_reg <= 1'b0;
                error_reg        <= '0;
            end
            else
            begin
                error_reg <= diff;
                if (below)
                    violation_on_reg <= 1'b0;
                else if (!violation_on_reg)
                begin
                    violation_on_reg    <= 1'b1;
                    violation_start_reg <= s1_time_reg;
                end
                else
                    fault_reg <= expired;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    assign out_valid       = out_valid_reg;
    assign hard_stop_fault = fault_reg;
    assign tracking_error  = error_reg;

`ifndef ASSERT_OFF
    a_violation_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        violation_on_reg |-> armed_reg)
        else $error("violation active without an armed move");

    a_fault_nonneg_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hard_stop_fault) |-> !tracking_error[COUNT_W-1])
        else $error("fault raised with a negative tracking error");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_dir_reg == DIR_STOP) |=>
            (!armed_reg && !violation_on_reg && !hard_stop_fault && tracking_error == '0))
        else $error("stop sample did not clear the move state");

    a_rearm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_dir_reg != DIR_STOP && rearm) |=>
            (armed_reg && !violation_on_reg && !hard_stop_fault && tracking_error == '0))
        else $error("rearm sample reported a nonzero result");

    a_beat_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid)
        else $error("advanced sample produced no result beat");
`endif

endmodule
